[hdl/point_range_grey_encoder_assert.svh]
// Assertion macros for the point range grey encoder.
`ifndef POINT_RANGE_GREY_ENCODER_ASSERT_SVH
`define POINT_RANGE_GREY_ENCODER_ASSERT_SVH

`ifndef ASSERT_OFF

// Check a condition at every clock edge outside reset.
`define PRGE_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("%m: assertion failed");

// Check that a consequent holds in the same cycle as its antecedent.
`define PRGE_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

`else

`define PRGE_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define PRGE_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)

`endif

`endif

[hdl/prge_pkg.sv]
// Shared types and constants of the point range grey encoder.
package prge_pkg;

   localparam int COORD_W    = 16;
   localparam int ECHO_W     = 17;
   localparam int CFG_W      = 16;
   localparam int GREY_W     = 8;
   localparam int SQ_W       = 2 * COORD_W;
   localparam int ROOT_CELLS = SQ_W / 2;
   localparam int DIV_CELLS  = GREY_W;
   localparam int QPOS_W     = $clog2(DIV_CELLS);
   localparam int DIFF_W     = CFG_W + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int BASE_W     = 2 * CFG_W;
   localparam int TOTAL_W    = PROD_W + 1;
   localparam int REM_W      = BASE_W + 1;
   localparam int CSR_IDX_W  = 3;

   localparam logic [GREY_W-1:0] GREY_MAX = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_RANGE       = 3'd0,
      CSR_MAX_RANGE       = 3'd1,
      CSR_MIN_GREY        = 3'd2,
      CSR_MAX_GREY        = 3'd3,
      CSR_BLACK_THRESHOLD = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] min_range;
      logic [CFG_W-1:0] max_range;
      logic [CFG_W-1:0] min_grey;
      logic [CFG_W-1:0] max_grey;
      logic [CFG_W-1:0] black_threshold;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      min_range:       16'd16383,
      max_range:       16'd0,
      min_grey:        16'd0,
      max_grey:        16'd65533,
      black_threshold: 16'd26
   };

   // Word moving down the square root chain.
   typedef struct packed {
      logic [SQ_W-1:0]   rem;
      logic [SQ_W-1:0]   root;
      logic [GREY_W-1:0] igrey;
   } root_word_type;

   // Word moving down the divider chain.
   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [CFG_W-1:0]  den;
      logic [GREY_W-1:0] quot;
      logic              force_en;
      logic [GREY_W-1:0] force_val;
      logic [GREY_W-1:0] igrey;
   } div_word_type;

endpackage

[hdl/point_range_grey_encoder.sv]
// Top level of the point range grey encoder: lidar point in, two grey bytes out.
//
// Input channel (req_*): one point per word, signed x/y/z in 1/256 m units and a
// signed integer echo level. Result channel (rsp_*): one word per point, the
// echo level clamped to 0..255 and the range mapped onto the grey ramp.
// Both channels use valid/ready; a word moves when valid and ready are high.
// Configuration (csr_*): write csr_wdata to the register at csr_index when
// csr_write_en is high; indexes beyond the list are dropped. Write only idle.
// Throughput: one point per cycle while the receiver keeps rsp_ready high. Every
// stage holds a valid bit and takes a new word whenever it is empty or its
// neighbor takes its word, so bubbles collapse and a point enters while the
// output register still waits. Pipeline: 30 register stages: squares, sum,
// 16 square root cells, clamp, multiply, sum, 8 divider cells and the output
// register.
// Reset: all stages empty, configuration registers at their reset values.
// When the receiver stalls, words pile up stage by stage; req_ready falls
// only once every stage is full.
`include "point_range_grey_encoder_assert.svh"

module point_range_grey_encoder (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [prge_pkg::COORD_W-1:0]   req_pos_x,
   input  logic signed [prge_pkg::COORD_W-1:0]   req_pos_y,
   input  logic signed [prge_pkg::COORD_W-1:0]   req_pos_z,
   input  logic signed [prge_pkg::ECHO_W-1:0]    req_echo_level,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [prge_pkg::GREY_W-1:0]           rsp_intensity_grey,
   output logic [prge_pkg::GREY_W-1:0]           rsp_range_grey,
   input  logic                                  csr_write_en,
   input  logic [prge_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [prge_pkg::CFG_W-1:0]            csr_wdata
);
   import prge_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // square stage
   logic              a_valid_ff, a_valid_in, a_ready;
   logic [SQ_W-1:0]   a_sqx_ff, a_sqy_ff, a_sqz_ff;
   logic [SQ_W-1:0]   a_sqx_in, a_sqy_in, a_sqz_in;
   logic [GREY_W-1:0] a_igrey_ff, a_igrey_in;
   // sum stage
   logic              b_valid_ff, b_valid_in, b_ready;
   root_word_type     b_word_ff, b_word_in;

   // chains: index 0 feeds the first cell, the last index leaves the chain
   logic          root_v [ROOT_CELLS+1];
   logic          root_r [ROOT_CELLS+1];
   root_word_type root_w [ROOT_CELLS+1];
   logic          div_v [DIV_CELLS+1];
   logic          div_r [DIV_CELLS+1];
   div_word_type  div_w [DIV_CELLS+1];

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [GREY_W-1:0] rsp_igrey_ff, rsp_rgrey_ff;
   logic [GREY_W-1:0] rsp_rgrey_in;

   // Configuration registers: drop writes to unknown indexes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_RANGE:       cfg_in.min_range       = csr_wdata;
            CSR_MAX_RANGE:       cfg_in.max_range       = csr_wdata;
            CSR_MIN_GREY:        cfg_in.min_grey        = csr_wdata;
            CSR_MAX_GREY:        cfg_in.max_grey        = csr_wdata;
            CSR_BLACK_THRESHOLD: cfg_in.black_threshold = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Square stage: three independent 16x16 products, echo clamp alongside.
   assign a_ready   = !a_valid_ff || b_ready;
   assign req_ready = a_ready;
   assign a_valid_in = a_ready ? req_valid : a_valid_ff;
   assign a_sqx_in  = SQ_W'(req_pos_x) * SQ_W'(req_pos_x);
   assign a_sqy_in  = SQ_W'(req_pos_y) * SQ_W'(req_pos_y);
   assign a_sqz_in  = SQ_W'(req_pos_z) * SQ_W'(req_pos_z);

   always_comb begin
      if (req_echo_level[ECHO_W-1]) begin
         a_igrey_in = '0;
      end else if (req_echo_level[ECHO_W-2:GREY_W] != '0) begin
         a_igrey_in = GREY_MAX;
      end else begin
         a_igrey_in = req_echo_level[GREY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && a_ready) begin
         a_sqx_ff   <= a_sqx_in;
         a_sqy_ff   <= a_sqy_in;
         a_sqz_ff   <= a_sqz_in;
         a_igrey_ff <= a_igrey_in;
      end
   end

   // Sum stage: squared range, at most 3 * 2^30 so it fits the word.
   assign b_ready    = !b_valid_ff || root_r[0];
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;

   always_comb begin
      b_word_in.rem   = a_sqx_ff + a_sqy_ff + a_sqz_ff;
      b_word_in.root  = '0;
      b_word_in.igrey = a_igrey_ff;
   end

   always_ff @(posedge clock) begin
      if (a_valid_ff && b_ready) begin
         b_word_ff <= b_word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   // Square root chain: cell i tries the bit of weight 4^(15-i).
   assign root_v[0] = b_valid_ff;
   assign root_w[0] = b_word_ff;

   for (genvar i = 0; i < ROOT_CELLS; i++) begin : g_root
      prge_root_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .trial_bit (SQ_W'(1) << (2 * (ROOT_CELLS - 1 - i))),
         .up_valid  (root_v[i]),
         .up_ready  (root_r[i]),
         .up_word   (root_w[i]),
         .dn_valid  (root_v[i+1]),
         .dn_ready  (root_r[i+1]),
         .dn_word   (root_w[i+1])
      );
   end

   // Clamp, product and sum set up the dividend for the divider chain.
   prge_map u_map (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .up_valid (root_v[ROOT_CELLS]),
      .up_ready (root_r[ROOT_CELLS]),
      .up_word  (root_w[ROOT_CELLS]),
      .dn_valid (div_v[0]),
      .dn_ready (div_r[0]),
      .dn_word  (div_w[0])
   );

   // Divider chain: cell i settles quotient bit 7-i.
   for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
      prge_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .quot_pos (QPOS_W'(DIV_CELLS - 1 - i)),
         .up_valid (div_v[i]),
         .up_ready (div_r[i]),
         .up_word  (div_w[i]),
         .dn_valid (div_v[i+1]),
         .dn_ready (div_r[i+1]),
         .dn_word  (div_w[i+1])
      );
   end

   // Output register: too-near and equal-range points take the forced value.
   assign div_r[DIV_CELLS] = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = div_r[DIV_CELLS] ? div_v[DIV_CELLS] : rsp_valid_ff;
   assign rsp_rgrey_in = div_w[DIV_CELLS].force_en ? div_w[DIV_CELLS].force_val
                                                   : div_w[DIV_CELLS].quot;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (div_v[DIV_CELLS] && div_r[DIV_CELLS]) begin
         rsp_igrey_ff <= div_w[DIV_CELLS].igrey;
         rsp_rgrey_ff <= rsp_rgrey_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_intensity_grey = rsp_igrey_ff;
   assign rsp_range_grey     = rsp_rgrey_ff;

   // Root leaving the chain is the floor: what remains is at most twice the root.
   `PRGE_ASSERT_IMPLIES(a_root_floor, clock, reset, root_v[ROOT_CELLS],
      {1'b0, root_w[ROOT_CELLS].rem} <= {root_w[ROOT_CELLS].root, 1'b0})

   // Quotient fits eight bits: the remainder ends below one scaled divisor.
   `PRGE_ASSERT_IMPLIES(a_div_fits, clock, reset,
      div_v[DIV_CELLS] && (div_w[DIV_CELLS].den != '0),
      div_w[DIV_CELLS].rem < REM_W'({div_w[DIV_CELLS].den, {GREY_W{1'b0}}}))

   // An empty first stage always takes a word.
   `PRGE_ASSERT_IMPLIES(a_ready_when_empty, clock, reset, !a_valid_ff, req_ready)

endmodule

[hdl/prge_root_cell.sv]
// One cell of the square root chain: settles one result bit per cell.
module prge_root_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [prge_pkg::SQ_W-1:0]     trial_bit,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  prge_pkg::root_word_type       up_word,
   output logic                          dn_valid,
   input  logic                          dn_ready,
   output prge_pkg::root_word_type       dn_word
);
   import prge_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   root_word_type word_ff;
   root_word_type word_in;
   logic [SQ_W:0] trial;

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_word  = word_ff;

   always_comb begin
      trial   = {1'b0, up_word.root} + {1'b0, trial_bit};
      word_in = up_word;
      if ({1'b0, up_word.rem} >= trial) begin
         word_in.rem  = up_word.rem - trial[SQ_W-1:0];
         word_in.root = (up_word.root >> 1) + trial_bit;
      end else begin
         word_in.root = up_word.root >> 1;
      end
   end

   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         word_ff <= word_in;
      end
   end

endmodule

[hdl/prge_div_cell.sv]
// One cell of the divider chain: settles one quotient bit per cell.
module prge_div_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [prge_pkg::QPOS_W-1:0]   quot_pos,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  prge_pkg::div_word_type        up_word,
   output logic                          dn_valid,
   input  logic                          dn_ready,
   output prge_pkg::div_word_type        dn_word
);
   import prge_pkg::*;

   logic             valid_ff;
   logic             valid_in;
   div_word_type     word_ff;
   div_word_type     word_in;
   logic [REM_W-1:0] divisor;

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_word  = word_ff;

   // Divisor is den scaled by the grey fraction, then by this cell's weight.
   always_comb begin
      divisor = REM_W'({up_word.den, {GREY_W{1'b0}}}) << quot_pos;
      word_in = up_word;
      if (up_word.rem >= divisor) begin
         word_in.rem            = up_word.rem - divisor;
         word_in.quot[quot_pos] = 1'b1;
      end
   end

   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         word_ff <= word_in;
      end
   end

endmodule

[hdl/prge_map.sv]
// Range clamp and linear map set-up: clamp, multiply and sum in three stages.
module prge_map (
   input  logic                          clock,
   input  logic                          reset,
   input  prge_pkg::cfg_type             cfg,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  prge_pkg::root_word_type       up_word,
   output logic                          dn_valid,
   input  logic                          dn_ready,
   output prge_pkg::div_word_type        dn_word
);
   import prge_pkg::*;

   // clamp stage
   logic                     c_valid_ff, c_valid_in, c_ready;
   logic signed [DIFF_W-1:0] c_diff_ff, c_diff_in;
   logic signed [DIFF_W-1:0] c_dg_ff, c_dg_in;
   logic [CFG_W-1:0]         c_den_ff, c_den_in;
   logic                     c_force_en_ff, c_force_en_in;
   logic [GREY_W-1:0]        c_force_val_ff, c_force_val_in;
   logic [GREY_W-1:0]        c_igrey_ff;
   // multiply stage
   logic                     d_valid_ff, d_valid_in, d_ready;
   logic signed [PROD_W-1:0] d_num_ff, d_num_in;
   logic [BASE_W-1:0]        d_base_ff, d_base_in;
   logic [CFG_W-1:0]         d_den_ff;
   logic                     d_force_en_ff;
   logic [GREY_W-1:0]        d_force_val_ff;
   logic [GREY_W-1:0]        d_igrey_ff;
   // sum stage
   logic                      e_valid_ff, e_valid_in, e_ready;
   div_word_type              e_word_ff, e_word_in;
   logic signed [TOTAL_W-1:0] total;

   logic [CFG_W-1:0] lo, hi, r_raw, r_cl;
   logic             reversed;

   // clamp stage
   assign c_ready = !c_valid_ff || d_ready;
   assign up_ready = c_ready;

   always_comb begin
      r_raw    = up_word.root[CFG_W-1:0];
      reversed = cfg.min_range > cfg.max_range;
      lo       = reversed ? cfg.max_range : cfg.min_range;
      hi       = reversed ? cfg.min_range : cfg.max_range;
      r_cl     = r_raw;
      if (r_raw < lo) begin
         r_cl = lo;
      end
      if (r_raw > hi) begin
         r_cl = hi;
      end
      // A falling range axis flips both numerator and denominator signs.
      if (reversed) begin
         c_diff_in = $signed({1'b0, cfg.min_range}) - $signed({1'b0, r_cl});
         c_den_in  = cfg.min_range - cfg.max_range;
      end else begin
         c_diff_in = $signed({1'b0, r_cl}) - $signed({1'b0, cfg.min_range});
         c_den_in  = cfg.max_range - cfg.min_range;
      end
      c_dg_in = $signed({1'b0, cfg.max_grey}) - $signed({1'b0, cfg.min_grey});
      if (up_word.root < SQ_W'(cfg.black_threshold)) begin
         c_force_en_in  = 1'b1;
         c_force_val_in = '0;
      end else if (cfg.min_range == cfg.max_range) begin
         c_force_en_in  = 1'b1;
         c_force_val_in = cfg.min_grey[CFG_W-1 -: GREY_W];
      end else begin
         c_force_en_in  = 1'b0;
         c_force_val_in = '0;
      end
   end

   assign c_valid_in = c_ready ? up_valid : c_valid_ff;

   always_ff @(posedge clock) begin
      if (up_valid && c_ready) begin
         c_diff_ff      <= c_diff_in;
         c_dg_ff        <= c_dg_in;
         c_den_ff       <= c_den_in;
         c_force_en_ff  <= c_force_en_in;
         c_force_val_ff <= c_force_val_in;
         c_igrey_ff     <= up_word.igrey;
      end
   end

   // multiply stage
   assign d_ready    = !d_valid_ff || e_ready;
   assign d_valid_in = d_ready ? c_valid_ff : d_valid_ff;
   assign d_num_in   = PROD_W'(c_diff_ff) * PROD_W'(c_dg_ff);
   assign d_base_in  = BASE_W'(cfg.min_grey) * BASE_W'(c_den_ff);

   always_ff @(posedge clock) begin
      if (c_valid_ff && d_ready) begin
         d_num_ff       <= d_num_in;
         d_base_ff      <= d_base_in;
         d_den_ff       <= c_den_ff;
         d_force_en_ff  <= c_force_en_ff;
         d_force_val_ff <= c_force_val_ff;
         d_igrey_ff     <= c_igrey_ff;
      end
   end

   // sum stage
   assign e_ready    = !e_valid_ff || dn_ready;
   assign e_valid_in = e_ready ? d_valid_ff : e_valid_ff;

   always_comb begin
      total               = $signed(TOTAL_W'(d_base_ff)) + TOTAL_W'(d_num_ff);
      e_word_in.rem       = total[TOTAL_W-1] ? '0 : total[REM_W-1:0];
      e_word_in.den       = d_den_ff;
      e_word_in.quot      = '0;
      e_word_in.force_en  = d_force_en_ff;
      e_word_in.force_val = d_force_val_ff;
      e_word_in.igrey     = d_igrey_ff;
   end

   always_ff @(posedge clock) begin
      if (d_valid_ff && e_ready) begin
         e_word_ff <= e_word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
         e_valid_ff <= e_valid_in;
      end
   end

   assign dn_valid = e_valid_ff;
   assign dn_word  = e_word_ff;

endmodule

[bench/point_range_grey_encoder_tb.sv]
// Self-checking bench for the point range grey encoder: random lidar points, shadow predictor.
module point_range_grey_encoder_tb;

   import prge_pkg::*;

   localparam int HALF_PERIOD  = 4;
   localparam int RESET_CYCLES = 3;
   localparam int MAX_IDLE     = 7;
   localparam int RANDOM_PER_PHASE = 66;
   localparam int RANDOM_PHASES    = 3;
   // The pipeline is 30 deep, output register included; leave some slack beyond that.
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 200000;
   // Margin around the ramp ends when aiming points at the clamp edges.
   localparam int RAMP_MARGIN  = 64;
   localparam int COORD_MAX    = 2 ** (COORD_W - 1) - 1;

   typedef struct {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic signed [ECHO_W-1:0]  echo_level;
   } point_type;

   typedef struct {
      logic [GREY_W-1:0] intensity_grey;
      logic [GREY_W-1:0] range_grey;
   } grey_pair_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic signed [COORD_W-1:0] req_pos_x;
   logic signed [COORD_W-1:0] req_pos_y;
   logic signed [COORD_W-1:0] req_pos_z;
   logic signed [ECHO_W-1:0]  req_echo_level;
   logic rsp_valid;
   logic rsp_ready;
   logic [GREY_W-1:0] rsp_intensity_grey;
   logic [GREY_W-1:0] rsp_range_grey;
   logic csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   // Register contents as the block should hold them.
   cfg_type csr_shadow = CFG_RESET;

   point_type     points_to_send[$];
   grey_pair_type pending_greys[$];
   int points_queued   = 0;
   int points_accepted = 0;
   int mismatches      = 0;
   int cycle_count     = 0;

   // Handshake flags seen at the last rising edge, read by the falling-edge drivers.
   logic point_taken = 1'b0;
   logic grey_taken  = 1'b0;
   int   req_hold    = 0;
   int   rsp_hold    = 0;
   bit   req_idle    = 1'b0;
   bit   rsp_idle    = 1'b0;

   point_range_grey_encoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_pos_z          (req_pos_z),
      .req_echo_level     (req_echo_level),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_intensity_grey (rsp_intensity_grey),
      .rsp_range_grey     (rsp_range_grey),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Grey pair of one point under the given registers. The range is the floored
   // Euclidean length; it is clamped into the ordered register pair and then mapped
   // along the ramp that runs from min_range/min_grey to max_range/max_grey.
   function automatic grey_pair_type grey_of_point(point_type p, cfg_type c);
      longint x, y, z, e, sq, root, trial, r;
      longint mr, xr, mg, xg, thr, lo, hi, den, num, total, grey;
      grey_pair_type g;
      x = longint'(p.pos_x);
      y = longint'(p.pos_y);
      z = longint'(p.pos_z);
      e = longint'(p.echo_level);
      mr = longint'(c.min_range);
      xr = longint'(c.max_range);
      mg = longint'(c.min_grey);
      xg = longint'(c.max_grey);
      thr = longint'(c.black_threshold);
      sq = x * x + y * y + z * z;
      // Build the root one bit at a time, most significant first.
      root = 0;
      for (int b = COORD_W - 1; b >= 0; b--) begin
         trial = root + (longint'(1) << b);
         if (trial * trial <= sq) root = trial;
      end
      // Compare as signed numbers so that negative echo levels clamp to zero.
      g.intensity_grey = (e > longint'(GREY_MAX)) ? GREY_MAX :
                         (e < 0) ? '0 : e[GREY_W-1:0];
      lo = (mr < xr) ? mr : xr;
      hi = (mr < xr) ? xr : mr;
      r = (root < lo) ? lo : (root > hi) ? hi : root;
      if (mr == xr) begin
         grey = mg >> GREY_W;
      end else begin
         den = xr - mr;
         num = (r - mr) * (xg - mg);
         // Flip a falling range axis so the divisor stays positive.
         if (den < 0) begin
            den = -den;
            num = -num;
         end
         total = mg * den + num;
         if (total < 0) total = 0;
         grey = total / (den << GREY_W);
         if (grey > longint'(GREY_MAX)) grey = longint'(GREY_MAX);
      end
      if (root < thr) grey = 0;
      g.range_grey = grey[GREY_W-1:0];
      return g;
   endfunction

   // Random point: half aimed at the ramp and its clamp edges, four in ten anywhere,
   // one in ten right around the origin where the black threshold bites.
   function automatic point_type random_point(cfg_type c);
      point_type p;
      int kind, lo, hi, r;
      kind = int'($urandom_range(0, 9));
      p.pos_x = COORD_W'($urandom);
      p.pos_y = COORD_W'($urandom);
      p.pos_z = COORD_W'($urandom);
      if (kind >= 4 && kind <= 8) begin
         lo = (c.min_range < c.max_range) ? int'(c.min_range) : int'(c.max_range);
         hi = (c.min_range < c.max_range) ? int'(c.max_range) : int'(c.min_range);
         lo = (lo > RAMP_MARGIN) ? lo - RAMP_MARGIN : 0;
         hi = (hi + RAMP_MARGIN > COORD_MAX) ? COORD_MAX : hi + RAMP_MARGIN;
         if (lo > hi) lo = hi;
         r = int'($urandom_range(hi, lo));
         p.pos_x = COORD_W'($urandom_range(0, 1) ? -r : r);
         p.pos_y = COORD_W'(int'($urandom_range(0, 254)) - 127);
         p.pos_z = COORD_W'(int'($urandom_range(0, 254)) - 127);
      end else if (kind == 9) begin
         p.pos_x = COORD_W'(int'($urandom_range(0, 128)) - 64);
         p.pos_y = COORD_W'(int'($urandom_range(0, 128)) - 64);
         p.pos_z = COORD_W'(int'($urandom_range(0, 128)) - 64);
      end
      if ($urandom_range(0, 1))
         p.echo_level = ECHO_W'(int'($urandom_range(0, 300)) - 20);
      else
         p.echo_level = ECHO_W'($urandom);
      return p;
   endfunction

   task automatic queue_point(int x, int y, int z, int e);
      point_type p;
      p.pos_x = COORD_W'(x);
      p.pos_y = COORD_W'(y);
      p.pos_z = COORD_W'(z);
      p.echo_level = ECHO_W'(e);
      points_to_send.push_back(p);
      points_queued++;
   endtask

   // Queue the clamp and threshold edges of the current registers, then random points.
   task automatic queue_phase_points(int count);
      int edges[6];
      int lo, hi, thr;
      point_type p;
      lo  = (csr_shadow.min_range < csr_shadow.max_range) ?
            int'(csr_shadow.min_range) : int'(csr_shadow.max_range);
      hi  = (csr_shadow.min_range < csr_shadow.max_range) ?
            int'(csr_shadow.max_range) : int'(csr_shadow.min_range);
      thr = int'(csr_shadow.black_threshold);
      edges = '{thr - 1, thr, lo - 1, lo, hi, hi + 1};
      foreach (edges[i]) begin
         if (edges[i] >= 0 && edges[i] <= COORD_MAX)
            queue_point(edges[i], 0, 0, int'($urandom_range(0, 255)));
      end
      for (int i = 0; i < count; i++) begin
         p = random_point(csr_shadow);
         points_to_send.push_back(p);
         points_queued++;
      end
   endtask

   // Write every register, then the unused indexes with junk, which must not stick.
   task automatic load_config(cfg_type c);
      logic [CSR_IDX_W-1:0] idx;
      logic [CFG_W-1:0]     val;
      for (int i = 0; i < 2 ** CSR_IDX_W; i++) begin
         idx = i[CSR_IDX_W-1:0];
         case (idx)
            CSR_MIN_RANGE:       val = c.min_range;
            CSR_MAX_RANGE:       val = c.max_range;
            CSR_MIN_GREY:        val = c.min_grey;
            CSR_MAX_GREY:        val = c.max_grey;
            CSR_BLACK_THRESHOLD: val = c.black_threshold;
            default:             val = CFG_W'($urandom);
         endcase
         @(negedge clock);
         csr_write_en <= 1'b1;
         csr_index    <= idx;
         csr_wdata    <= val;
      end
      @(negedge clock);
      csr_write_en <= 1'b0;
      csr_shadow = c;
   endtask

   task automatic wait_drained();
      while (points_accepted != points_queued || pending_greys.size() != 0)
         @(negedge clock);
   endtask

   // Driver: present the next point once the current one is taken and its gap is over.
   always @(negedge clock) begin
      point_type pt;
      if (!req_valid || point_taken) begin
         if (req_hold > 0) begin
            req_hold--;
            req_valid <= 1'b0;
         end else if (points_to_send.size() != 0) begin
            pt = points_to_send.pop_front();
            req_pos_x      <= pt.pos_x;
            req_pos_y      <= pt.pos_y;
            req_pos_z      <= pt.pos_z;
            req_echo_level <= pt.echo_level;
            req_valid      <= 1'b1;
            req_hold = req_idle ? int'($urandom_range(0, MAX_IDLE)) : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: when rsp_idle is set, stall for a fresh random count after every word taken.
   always @(negedge clock) begin
      if (grey_taken) rsp_hold = rsp_idle ? int'($urandom_range(0, MAX_IDLE)) : 0;
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: predict on every accepted point, check every accepted grey pair.
   always @(posedge clock) begin
      point_type     seen;
      grey_pair_type want;
      if (reset) begin
         point_taken <= 1'b0;
         grey_taken  <= 1'b0;
      end else begin
         point_taken <= req_valid && req_ready;
         grey_taken  <= rsp_valid && rsp_ready;
         if (req_valid && req_ready) begin
            seen.pos_x      = req_pos_x;
            seen.pos_y      = req_pos_y;
            seen.pos_z      = req_pos_z;
            seen.echo_level = req_echo_level;
            pending_greys.push_back(grey_of_point(seen, csr_shadow));
            points_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_greys.size() == 0) begin
               $display("%0t: unexpected word intensity_grey %0d range_grey %0d",
                        $time, rsp_intensity_grey, rsp_range_grey);
               mismatches++;
            end else begin
               want = pending_greys.pop_front();
               if (rsp_intensity_grey !== want.intensity_grey) begin
                  $display("%0t: intensity_grey expected %0d got %0d",
                           $time, want.intensity_grey, rsp_intensity_grey);
                  mismatches++;
               end
               if (rsp_range_grey !== want.range_grey) begin
                  $display("%0t: range_grey expected %0d got %0d",
                           $time, want.range_grey, rsp_range_grey);
                  mismatches++;
               end
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("point_range_grey_encoder_tb: FAIL");
         $finish;
      end
   end

   initial begin
      cfg_type ramp_settings[7];
      cfg_type pick;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_pos_x      = '0;
      req_pos_y      = '0;
      req_pos_z      = '0;
      req_echo_level = '0;
      rsp_ready      = 1'b0;
      csr_write_en   = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;

      // Normal ramp, reversed ranges, falling greys, equal ranges, all zero,
      // all ones (everything black), and the widest rising ramp.
      ramp_settings[0] = '{min_range: 16'd256, max_range: 16'd8192, min_grey: 16'd0,
                           max_grey: 16'hFFFF, black_threshold: 16'd128};
      ramp_settings[1] = '{min_range: 16'd20000, max_range: 16'd1000, min_grey: 16'd1000,
                           max_grey: 16'd60000, black_threshold: 16'd0};
      ramp_settings[2] = '{min_range: 16'd500, max_range: 16'd30000, min_grey: 16'hFFFF,
                           max_grey: 16'd0, black_threshold: 16'd300};
      ramp_settings[3] = '{min_range: 16'd5000, max_range: 16'd5000, min_grey: 16'h7F80,
                           max_grey: 16'd1234, black_threshold: 16'd10};
      ramp_settings[4] = '{min_range: 16'd0, max_range: 16'd0, min_grey: 16'd0,
                           max_grey: 16'd0, black_threshold: 16'd0};
      ramp_settings[5] = '{min_range: 16'hFFFF, max_range: 16'hFFFF, min_grey: 16'hFFFF,
                           max_grey: 16'hFFFF, black_threshold: 16'hFFFF};
      ramp_settings[6] = '{min_range: 16'd0, max_range: 16'hFFFF, min_grey: 16'd0,
                           max_grey: 16'hFFFF, black_threshold: 16'd1};

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset registers: reversed ranges and the near-origin threshold. Hit the
      // field extremes, the intensity clamp edges and the threshold edge.
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      queue_point(0, 0, 0, 0);
      queue_point(-32768, -32768, -32768, -65536);
      queue_point(32767, 32767, 32767, 65535);
      queue_point(32767, -32768, 0, 255);
      queue_point(-32768, 0, 0, 256);
      queue_point(0, 0, -1, -1);
      queue_point(25, 0, 0, 1);
      queue_point(0, 26, 0, 254);
      queue_point(0, 16383, 0, 0);
      queue_point(0, 0, 16384, 100);
      queue_point(8000, -8000, 3, 128);
      queue_point(-1, -1, -1, -65536);
      queue_phase_points(RANDOM_PER_PHASE);
      wait_drained();

      for (int ph = 0; ph < 7 + RANDOM_PHASES; ph++) begin
         if (ph < 7) begin
            pick = ramp_settings[ph];
         end else begin
            pick.min_range       = CFG_W'($urandom);
            pick.max_range       = $urandom_range(0, 3) ? CFG_W'($urandom) : pick.min_range;
            pick.min_grey        = CFG_W'($urandom);
            pick.max_grey        = CFG_W'($urandom);
            pick.black_threshold = CFG_W'($urandom_range(0, 2047));
         end
         // Cycle through no gaps, an idling sender, a stalling receiver, and both.
         req_idle = ph[0];
         rsp_idle = ph[1];
         load_config(pick);
         queue_phase_points(RANDOM_PER_PHASE);
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_greys.size() == 0)
         $display("point_range_grey_encoder_tb: PASS");
      else
         $display("point_range_grey_encoder_tb: FAIL");
      $finish;
   end

endmodule

[sim.f]
+incdir+hdl
hdl/prge_pkg.sv
hdl/prge_root_cell.sv
hdl/prge_div_cell.sv
hdl/prge_map.sv
hdl/point_range_grey_encoder.sv
bench/point_range_grey_encoder_tb.sv
